/* rtl/sliding_window_median_filter_top_macros.svh */
// Assertion macros for the running median filter checker.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SWMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swmf check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SWMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swmf check failed");

`endif

/* rtl/swmf_pkg.sv */
// Shared constants and types for the running median filter.
`default_nettype none
package swmf_pkg;

    localparam int MAX_WINDOW   = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int WLEN_W       = 6;
    localparam int WLEN_RESET   = 15;
    localparam int IDX_W        = $clog2(MAX_WINDOW);
    localparam int LEN_W        = IDX_W + 1;

    // What one sort cell hands to the next one.
    typedef struct packed {
        logic                           gt;   // empty, or holds a value above the key
        logic                           full;
        logic signed [SAMPLE_WIDTH-1:0] val;
    } t_link;

endpackage
`default_nettype wire

/* rtl/swmf_cell.sv */
// One cell of the insertion sort row: holds one sorted value.
`default_nettype none
module swmf_cell (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_clear,
    input  wire logic                                    i_ins,
    input  wire logic signed [swmf_pkg::SAMPLE_WIDTH-1:0] i_key,
    input  wire swmf_pkg::t_link                         i_prev,
    output swmf_pkg::t_link                              o_link
);

    logic                                  r_full;
    logic                                  n_full;
    logic signed [swmf_pkg::SAMPLE_WIDTH-1:0] r_val;
    logic signed [swmf_pkg::SAMPLE_WIDTH-1:0] n_val;
    logic                                  w_gt;

    // An empty cell behaves as plus infinity.
    assign w_gt = !r_full || (r_val > i_key);

    always_comb begin
        n_full = r_full;
        n_val  = r_val;
        if (i_clear) begin
            n_full = 1'b0;
        end else if (i_ins && w_gt) begin
            if (i_prev.gt) begin
                // shift the neighbour's value up by one place
                n_val  = i_prev.val;
                n_full = i_prev.full;
            end else begin
                // the key lands here
                n_val  = i_key;
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link.gt   = w_gt;
    assign o_link.full = r_full;
    assign o_link.val  = r_val;

endmodule
`default_nettype wire

/* rtl/sliding_window_median_filter_top.sv */
// Top level of the running median filter: sample history, sort cell row, control.
//
//  channel  | direction | handshake                           | payload
//  ---------+-----------+-------------------------------------+---------------------
//  sample   | in        | i_sample_valid / o_sample_ready     | i_sample (s16)
//  median   | out       | o_median_valid / i_median_ready     | o_median (s16)
//  config   | in        | i_window_length_we (no wait)        | i_window_length (u6)
//
// An item goes through an accept, a sort and a pick, L being the window length
// clamped to 1..32: the sort row takes one history entry per cycle until it
// holds L entries, then the pick copies the middle cell into the output register.
// Reset (synchronous, active low) clears the history to zeros and sets the
// window length to 15. A stalled result sits in the output register while
// the next beat is accepted; only the pick cycle waits for it to drain.
`default_nettype none
module sliding_window_median_filter_top (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_window_length_we,
    input  wire logic [swmf_pkg::WLEN_W-1:0]             i_window_length,
    input  wire logic                                    i_sample_valid,
    output logic                                         o_sample_ready,
    input  wire logic signed [swmf_pkg::SAMPLE_WIDTH-1:0] i_sample,
    output logic                                         o_median_valid,
    input  wire logic                                    i_median_ready,
    output logic signed [swmf_pkg::SAMPLE_WIDTH-1:0]     o_median
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SORT = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [swmf_pkg::WLEN_W-1:0]      r_wlen;
    logic [swmf_pkg::IDX_W-1:0]       r_cnt;
    logic [swmf_pkg::IDX_W-1:0]       n_cnt;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic signed [swmf_pkg::SAMPLE_WIDTH-1:0] r_median;
    logic signed [swmf_pkg::SAMPLE_WIDTH-1:0] r_hist [swmf_pkg::MAX_WINDOW];

    logic [swmf_pkg::LEN_W-1:0]       w_len;
    logic [swmf_pkg::IDX_W-1:0]       w_last;
    logic [swmf_pkg::IDX_W-1:0]       w_mid;
    logic                             w_accept;
    logic                             w_pick;
    logic                             w_ins;
    logic signed [swmf_pkg::SAMPLE_WIDTH-1:0] w_key;
    swmf_pkg::t_link                  w_link [swmf_pkg::MAX_WINDOW];
    swmf_pkg::t_link                  w_prev [swmf_pkg::MAX_WINDOW];

    // Clamp the window length to 1..MAX_WINDOW.
    always_comb begin
        if (r_wlen == '0) begin
            w_len = swmf_pkg::LEN_W'(1);
        end else if (r_wlen > swmf_pkg::WLEN_W'(swmf_pkg::MAX_WINDOW)) begin
            w_len = swmf_pkg::LEN_W'(swmf_pkg::MAX_WINDOW);
        end else begin
            w_len = swmf_pkg::LEN_W'(r_wlen);
        end
    end

    assign w_last = swmf_pkg::IDX_W'(w_len - swmf_pkg::LEN_W'(1));
    assign w_mid  = w_len[swmf_pkg::LEN_W-1:1];

    assign o_sample_ready = (r_state == S_IDLE);
    assign w_accept       = i_sample_valid && o_sample_ready;
    assign w_ins          = (r_state == S_SORT);
    assign w_pick         = (r_state == S_PICK) && (!r_out_valid || i_median_ready);
    assign w_key          = r_hist[r_cnt];

    // Sequencer: accept, feed the window newest first, then pick.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SORT;
                    n_cnt   = '0;
                end
            end
            S_SORT: begin
                if (r_cnt == w_last) begin
                    n_state = S_PICK;
                end else begin
                    n_cnt = r_cnt + swmf_pkg::IDX_W'(1);
                end
            end
            S_PICK: begin
                if (w_pick) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Drop the result once taken; load a fresh one at the pick.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_median_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_pick) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_wlen      <= swmf_pkg::WLEN_W'(swmf_pkg::WLEN_RESET);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_window_length_we) begin
                r_wlen <= i_window_length;
            end
        end
    end

    // Sample history, newest in entry zero; advance on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < swmf_pkg::MAX_WINDOW; k++) begin
                r_hist[k] <= '0;
            end
        end else if (w_accept) begin
            r_hist[0] <= i_sample;
            for (int k = 1; k < swmf_pkg::MAX_WINDOW; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    // Hold the picked median until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (w_pick) begin
            r_median <= w_link[w_mid].val;
        end
    end

    // Sort cell row: cell zero holds the smallest value.
    assign w_prev[0] = '0;
    for (genvar g = 1; g < swmf_pkg::MAX_WINDOW; g++) begin : g_prev
        assign w_prev[g] = w_link[g-1];
    end

    for (genvar g = 0; g < swmf_pkg::MAX_WINDOW; g++) begin : g_cell
        swmf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_accept),
            .i_ins   (w_ins),
            .i_key   (w_key),
            .i_prev  (w_prev[g]),
            .o_link  (w_link[g])
        );
    end

    assign o_median_valid = r_out_valid;
    assign o_median       = r_median;

endmodule
`default_nettype wire

/* rtl/swmf_checker.sv */
// Port-level checks for the running median filter, bound to the top level.
`default_nettype none
`include "sliding_window_median_filter_top_macros.svh"
module swmf_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_sample_valid,
    input wire logic                              o_sample_ready,
    input wire logic                              o_median_valid,
    input wire logic                              i_median_ready,
    input wire logic [swmf_pkg::SAMPLE_WIDTH-1:0] o_median
);

    // A stalled result beat stays valid.
    `SWMF_ASSERT_NXT(a_out_hold, o_median_valid && !i_median_ready, o_median_valid)
    // ... and keeps its value.
    `SWMF_ASSERT_NXT(a_out_stable, o_median_valid && !i_median_ready, $stable(o_median))
    // One sample at a time: ready drops after an accepted beat.
    `SWMF_ASSERT_NXT(a_one_item, i_sample_valid && o_sample_ready, !o_sample_ready)
    // The sort comes before the pick, so ready is still low after the first sort step.
    `SWMF_ASSERT_IMP(a_min_busy, i_sample_valid && o_sample_ready, ##2 !o_sample_ready)
    // A fresh result only appears out of the pick cycle.
    `SWMF_ASSERT_IMP(a_rise_busy, $rose(o_median_valid), !$past(o_sample_ready))

endmodule

bind sliding_window_median_filter_top swmf_checker u_swmf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_sample_valid     (i_sample_valid),
    .o_sample_ready     (o_sample_ready),
    .o_median_valid     (o_median_valid),
    .i_median_ready     (i_median_ready),
    .o_median           (o_median)
);
`default_nettype wire
